FILE: rtl/core/ihex_pkg.sv
`default_nettype none

package ihex_pkg;

   // Parse position within one record line. Odd codes from PH_CNT_HI to PH_SUM_HI
   // wait for the first digit of a byte pair, the even codes after them complete a byte.
   typedef enum logic [3:0] {
      PH_COLON   = 4'd0,
      PH_CNT_HI  = 4'd1,
      PH_CNT_LO  = 4'd2,
      PH_ADH_HI  = 4'd3,
      PH_ADH_LO  = 4'd4,
      PH_ADL_HI  = 4'd5,
      PH_ADL_LO  = 4'd6,
      PH_TYP_HI  = 4'd7,
      PH_TYP_LO  = 4'd8,
      PH_DAT_HI  = 4'd9,
      PH_DAT_LO  = 4'd10,
      PH_SUM_HI  = 4'd11,
      PH_SUM_LO  = 4'd12,
      PH_TAIL    = 4'd13,
      PH_HALT    = 4'd14
   } phase_type;

   // Result kinds.
   typedef enum logic [1:0] {
      KIND_DATA   = 2'd0,
      KIND_RECORD = 2'd1,
      KIND_EOF    = 2'd2,
      KIND_ERROR  = 2'd3
   } kind_type;

   // Error codes reported with an error result.
   typedef enum logic [3:0] {
      ERR_NO_COLON = 4'd0,
      ERR_DIGIT    = 4'd1,
      ERR_SHORT    = 4'd2,
      ERR_CHECKSUM = 4'd3,
      ERR_EXTRA    = 4'd4,
      ERR_UNKNOWN  = 4'd5,
      ERR_UNIMPL   = 4'd6,
      ERR_COUNT    = 4'd7,
      ERR_EOF      = 4'd8
   } err_type;

   // Record types.
   localparam logic [7:0] REC_DATA  = 8'h00;
   localparam logic [7:0] REC_EOF   = 8'h01;
   localparam logic [7:0] REC_SEG   = 8'h02;
   localparam logic [7:0] REC_SSA   = 8'h03;
   localparam logic [7:0] REC_UPPER = 8'h04;
   localparam logic [7:0] REC_START = 8'h05;

   // Characters.
   localparam logic [7:0] CH_NEWLINE = 8'h0A;
   localparam logic [7:0] CH_COLON   = 8'h3A;
   localparam logic [7:0] CH_ZERO    = 8'h30;
   localparam logic [7:0] CH_NINE    = 8'h39;
   localparam logic [7:0] CH_UPPER_A = 8'h41;
   localparam logic [7:0] CH_UPPER_F = 8'h46;
   localparam logic [7:0] CH_LOWER_A = 8'h61;
   localparam logic [7:0] CH_LOWER_F = 8'h66;

   // Depth of the result queue and the width of its fill level.
   localparam int RSP_DEPTH = 3;
   localparam int LEVEL_W   = 2;

   // Fixed-width part of one result word.
   typedef struct packed {
      kind_type    kind;
      err_type     error_code;
      logic [31:0] address;
      logic [7:0]  data_byte;
      logic [7:0]  record_type;
      logic [7:0]  due_checksum;
   } rsp_fix_type;

   // Returns {not_hex, nibble} for one ASCII character.
   function automatic logic [4:0] hex_digit(input logic [7:0] c);
      logic [4:0] r;
      r = 5'h10;
      if (c >= CH_LOWER_A && c <= CH_LOWER_F) begin
         r = {1'b0, 4'(c - CH_LOWER_A) + 4'd10};
      end else if (c >= CH_UPPER_A && c <= CH_UPPER_F) begin
         r = {1'b0, 4'(c - CH_UPPER_A) + 4'd10};
      end else if (c >= CH_ZERO && c <= CH_NINE) begin
         r = {1'b0, 4'(c - CH_ZERO)};
      end
      return r;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/core/ihex_parse.sv
`default_nettype none

module ihex_parse
   import ihex_pkg::*;
#(
   parameter int LINE_NUMBER_WIDTH = 24
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         in_valid,
   input  wire logic                         in_eos,
   input  wire logic [7:0]                   in_char,
   output logic                              res_valid,
   output rsp_fix_type                       res_fix,
   output logic [LINE_NUMBER_WIDTH-1:0]      res_line
);

   phase_type                    phase_ff, phase_in;
   logic [3:0]                   nib_ff, nib_in;
   logic                         nib_bad_ff, nib_bad_in;
   logic [7:0]                   count_ff, count_in;
   logic [15:0]                  rec_addr_ff, rec_addr_in;
   logic [7:0]                   type_ff, type_in;
   logic [7:0]                   index_ff, index_in;
   logic [7:0]                   sum_ff, sum_in;
   logic [15:0]                  first_two_ff, first_two_in;
   logic [15:0]                  upper_ff, upper_in;
   logic [LINE_NUMBER_WIDTH-1:0] line_ff, line_in;

   logic [4:0]  digit;
   logic [7:0]  byte_val;
   logic [7:0]  index_next;
   logic [7:0]  expect_sum;
   logic [31:0] base_addr;
   logic        fail_hit;
   err_type     fail_err;

   assign digit      = hex_digit(in_char);
   assign byte_val   = {nib_ff, digit[3:0]};
   assign index_next = index_ff + 8'd1;
   assign expect_sum = 8'd0 - sum_ff;
   assign base_addr  = {upper_ff, rec_addr_ff};
   assign res_line   = line_ff;

   // Parser state register.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_COLON;
         nib_ff       <= '0;
         nib_bad_ff   <= 1'b0;
         count_ff     <= '0;
         rec_addr_ff  <= '0;
         type_ff      <= '0;
         index_ff     <= '0;
         sum_ff       <= '0;
         first_two_ff <= '0;
         upper_ff     <= '0;
         line_ff      <= LINE_NUMBER_WIDTH'(1);
      end else begin
         phase_ff     <= phase_in;
         nib_ff       <= nib_in;
         nib_bad_ff   <= nib_bad_in;
         count_ff     <= count_in;
         rec_addr_ff  <= rec_addr_in;
         type_ff      <= type_in;
         index_ff     <= index_in;
         sum_ff       <= sum_in;
         first_two_ff <= first_two_in;
         upper_ff     <= upper_in;
         line_ff      <= line_in;
      end
   end

   // Next state and result for the character in the input register.
   always_comb begin
      phase_in     = phase_ff;
      nib_in       = nib_ff;
      nib_bad_in   = nib_bad_ff;
      count_in     = count_ff;
      rec_addr_in  = rec_addr_ff;
      type_in      = type_ff;
      index_in     = index_ff;
      sum_in       = sum_ff;
      first_two_in = first_two_ff;
      upper_in     = upper_ff;
      line_in      = line_ff;

      fail_hit  = 1'b0;
      fail_err  = ERR_NO_COLON;
      res_valid = 1'b0;
      res_fix.kind         = KIND_DATA;
      res_fix.error_code   = ERR_NO_COLON;
      res_fix.address      = '0;
      res_fix.data_byte    = '0;
      res_fix.record_type  = type_ff;
      res_fix.due_checksum = '0;

      if (in_valid && phase_ff != PH_HALT) begin
         if (in_eos || in_char == CH_NEWLINE) begin
            // End of line: either an error or the record is finished.
            if (phase_ff == PH_COLON) begin
               fail_hit = 1'b1;
               fail_err = in_eos ? ERR_EOF : ERR_NO_COLON;
            end else if (phase_ff != PH_TAIL) begin
               fail_hit = 1'b1;
               fail_err = ERR_SHORT;
            end else begin
               case (type_ff)
                  REC_DATA, REC_SSA: begin
                  end
                  REC_UPPER: begin
                     if (count_ff != 8'd2) begin
                        fail_hit = 1'b1;
                        fail_err = ERR_COUNT;
                     end else begin
                        upper_in = first_two_ff;
                     end
                  end
                  REC_EOF: begin
                  end
                  REC_SEG, REC_START: begin
                     fail_hit = 1'b1;
                     fail_err = ERR_UNIMPL;
                  end
                  default: begin
                     fail_hit = 1'b1;
                     fail_err = ERR_UNKNOWN;
                  end
               endcase
               if (!fail_hit) begin
                  res_valid       = 1'b1;
                  res_fix.address = base_addr;
                  if (type_ff == REC_EOF) begin
                     res_fix.kind = KIND_EOF;
                     phase_in     = PH_HALT;
                  end else begin
                     res_fix.kind = KIND_RECORD;
                     phase_in     = PH_COLON;
                     if (~&line_ff) begin
                        line_in = line_ff + 1'b1;
                     end
                  end
               end
            end
         end else if (phase_ff == PH_COLON) begin
            // Start of a record clears its fields.
            if (in_char != CH_COLON) begin
               fail_hit = 1'b1;
               fail_err = ERR_NO_COLON;
            end else begin
               nib_in       = '0;
               nib_bad_in   = 1'b0;
               count_in     = '0;
               rec_addr_in  = '0;
               type_in      = '0;
               index_in     = '0;
               sum_in       = '0;
               first_two_in = '0;
               phase_in     = PH_CNT_HI;
            end
         end else if (phase_ff == PH_TAIL) begin
            fail_hit = 1'b1;
            fail_err = ERR_EXTRA;
         end else if (phase_ff[0]) begin
            // First digit of a pair is held until the second arrives.
            nib_in     = digit[3:0];
            nib_bad_in = digit[4];
            phase_in   = phase_type'(4'(phase_ff) + 4'd1);
         end else if (nib_bad_ff || digit[4]) begin
            fail_hit = 1'b1;
            fail_err = ERR_DIGIT;
         end else begin
            // A complete byte goes to its field and, unless it is the checksum, into the sum.
            sum_in = sum_ff + byte_val;
            case (phase_ff)
               PH_CNT_LO: begin
                  count_in = byte_val;
                  phase_in = PH_ADH_HI;
               end
               PH_ADH_LO: begin
                  rec_addr_in = {byte_val, 8'h00};
                  phase_in    = PH_ADL_HI;
               end
               PH_ADL_LO: begin
                  rec_addr_in = {rec_addr_ff[15:8], byte_val};
                  phase_in    = PH_TYP_HI;
               end
               PH_TYP_LO: begin
                  type_in  = byte_val;
                  phase_in = (count_ff != 8'd0) ? PH_DAT_HI : PH_SUM_HI;
               end
               PH_DAT_LO: begin
                  if (index_ff == 8'd0) begin
                     first_two_in = {byte_val, 8'h00};
                  end else if (index_ff == 8'd1) begin
                     first_two_in = {first_two_ff[15:8], byte_val};
                  end
                  if (type_ff == REC_DATA) begin
                     res_valid         = 1'b1;
                     res_fix.kind      = KIND_DATA;
                     res_fix.address   = base_addr + {24'd0, index_ff};
                     res_fix.data_byte = byte_val;
                  end
                  index_in = index_next;
                  phase_in = (index_next < count_ff) ? PH_DAT_HI : PH_SUM_HI;
               end
               default: begin
                  // Checksum byte.
                  sum_in = sum_ff;
                  if (byte_val != expect_sum) begin
                     fail_hit             = 1'b1;
                     fail_err             = ERR_CHECKSUM;
                     res_fix.due_checksum = expect_sum;
                  end else begin
                     phase_in = PH_TAIL;
                  end
               end
            endcase
         end

         // Any error halts the parser until reset.
         if (fail_hit) begin
            phase_in           = PH_HALT;
            res_valid          = 1'b1;
            res_fix.kind       = KIND_ERROR;
            res_fix.error_code = fail_err;
            res_fix.address    = '0;
            res_fix.data_byte  = '0;
         end
      end
   end

`ifndef NO_ASSERTIONS
   // Once halted, the parser stays halted.
   a_halt_sticky: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_HALT |=> phase_ff == PH_HALT)
      else $error("parser left the halted phase");

   // Data bytes are only emitted for data records.
   a_data_type: assert property (@(posedge clock) disable iff (reset)
      res_valid && res_fix.kind == KIND_DATA |-> type_ff == REC_DATA)
      else $error("data word from a non-data record");

   // The line number never drops to zero.
   a_line_nonzero: assert property (@(posedge clock) disable iff (reset)
      line_ff != '0)
      else $error("line number is zero");
`endif

endmodule

`default_nettype wire

FILE: rtl/core/ihex_rsp_fifo.sv
`default_nettype none

module ihex_rsp_fifo
   import ihex_pkg::*;
#(
   parameter int DATA_WIDTH = 96
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push,
   input  wire logic [DATA_WIDTH-1:0] push_data,
   output logic                       out_valid,
   input  wire logic                  out_stall,
   output logic [DATA_WIDTH-1:0]      out_data,
   output logic [LEVEL_W-1:0]         level
);

   logic [DATA_WIDTH-1:0] mem_ff [RSP_DEPTH];
   logic [LEVEL_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [LEVEL_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [LEVEL_W-1:0]    level_ff, level_in;
   logic                  pop;

   assign out_valid = level_ff != '0;
   assign out_data  = mem_ff[rd_ptr_ff];
   assign pop       = out_valid && !out_stall;
   assign level     = level_ff;

   // Pointer and fill level update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      level_in  = level_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LEVEL_W'(RSP_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LEVEL_W'(RSP_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         level_in = level_ff + 1'b1;
      end else if (pop && !push) begin
         level_in = level_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   // Result word storage.
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

`ifndef NO_ASSERTIONS
   // The upstream credit check must keep a slot free for every push.
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> level_ff != LEVEL_W'(RSP_DEPTH) || pop)
      else $error("result queue overflow");

   // The fill level stays within the queue depth.
   a_level_range: assert property (@(posedge clock) disable iff (reset)
      level_ff <= LEVEL_W'(RSP_DEPTH))
      else $error("result queue level out of range");
`endif

endmodule

`default_nettype wire

FILE: rtl/core/intel_hex_record_parser_unit.sv
`default_nettype none

// Intel HEX record parser. Each input word carries one ASCII character of a
// HEX file (or an end-of-stream mark); each result word is a data byte with
// its 32-bit address, a record-accepted or end-of-file notice, or an error.
// A character is held in the input register while the parser logic writes its
// result, if any, into a three-word result queue whose head drives the result
// ports, so a result leaves through the input register and the queue after
// its character was accepted. A new character is accepted every cycle as long
// as the consumer keeps taking results; req_stall rises when the queue is
// full, or holds two words while a character is in flight. After an error or
// an end-of-file record the parser ignores all input until reset.
module intel_hex_record_parser_unit
   import ihex_pkg::*;
#(
   parameter int LINE_NUMBER_WIDTH = 24
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire logic                         req_end_of_stream,
   input  wire logic [7:0]                   req_character,
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output logic [1:0]                        rsp_kind,
   output logic [3:0]                        rsp_error_code,
   output logic [31:0]                       rsp_address,
   output logic [7:0]                        rsp_data_byte,
   output logic [LINE_NUMBER_WIDTH-1:0]      rsp_line_number,
   output logic [7:0]                        rsp_record_type,
   output logic [7:0]                        rsp_due_checksum
);

   localparam int FIX_W = $bits(rsp_fix_type);
   localparam int RSP_W = FIX_W + LINE_NUMBER_WIDTH;

   logic                         in_valid_ff;
   logic                         in_eos_ff;
   logic [7:0]                   in_char_ff;
   logic                         req_accept;
   logic                         res_valid;
   rsp_fix_type                  res_fix;
   logic [LINE_NUMBER_WIDTH-1:0] res_line;
   logic [RSP_W-1:0]             out_word;
   rsp_fix_type                  out_fix;
   logic [LEVEL_W-1:0]           level;

   // Accept while the queue has room for this word and the one in flight.
   assign req_stall  = (level == LEVEL_W'(RSP_DEPTH)) ||
                       (level == LEVEL_W'(RSP_DEPTH - 1) && in_valid_ff);
   assign req_accept = req_valid && !req_stall;

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= req_accept;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_eos_ff  <= req_end_of_stream;
         in_char_ff <= req_character;
      end
   end

   ihex_parse #(
      .LINE_NUMBER_WIDTH(LINE_NUMBER_WIDTH)
   ) u_parse (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (in_valid_ff),
      .in_eos    (in_eos_ff),
      .in_char   (in_char_ff),
      .res_valid (res_valid),
      .res_fix   (res_fix),
      .res_line  (res_line)
   );

   ihex_rsp_fifo #(
      .DATA_WIDTH(RSP_W)
   ) u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (res_valid),
      .push_data ({res_line, res_fix}),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_data  (out_word),
      .level     (level)
   );

   // Unpack the result word onto the output ports.
   assign out_fix          = rsp_fix_type'(out_word[FIX_W-1:0]);
   assign rsp_line_number  = out_word[RSP_W-1:FIX_W];
   assign rsp_kind         = out_fix.kind;
   assign rsp_error_code   = out_fix.error_code;
   assign rsp_address      = out_fix.address;
   assign rsp_data_byte    = out_fix.data_byte;
   assign rsp_record_type  = out_fix.record_type;
   assign rsp_due_checksum = out_fix.due_checksum;

endmodule

`default_nettype wire

FILE: sim/intel_hex_record_parser_unit_tb.sv
`timescale 1ns / 1ps

module intel_hex_record_parser_unit_tb;
   import ihex_pkg::*;

   localparam int LINE_W      = 24;
   localparam int ITEM_TARGET = 1650;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int HOLD_AFTER  = 150;
   localparam int HOLD_CYCLES = 400;

   // Non-error results carry a zero error code.
   localparam err_type NO_ERROR = ERR_NO_COLON;

   // One character word as the sender offers it.
   typedef struct {
      logic       eos;
      logic [7:0] ch;
      int         gap;     // idle cycles before this word is offered
      bit         drain;   // offer only once every result has arrived
   } char_word_t;

   // One expected result word.
   typedef struct packed {
      kind_type          kind;
      err_type           code;
      logic [31:0]       address;
      logic [7:0]        data;
      logic [LINE_W-1:0] line;
      logic [7:0]        rtype;
      logic [7:0]        csum;
   } parse_result_t;

   // Ways in which the character stream is brought to its halt.
   typedef enum int {
      END_NO_COLON,
      END_EMPTY_LINE,
      END_EOS,
      END_DIGIT,
      END_SHORT,
      END_CHECKSUM,
      END_EXTRA,
      END_UNKNOWN,
      END_UNIMPL,
      END_COUNT,
      END_EOF_RECORD
   } ending_t;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic              req_end_of_stream = 1'b0;
   logic [7:0]        req_character = 8'h00;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic [1:0]        rsp_kind;
   logic [3:0]        rsp_error_code;
   logic [31:0]       rsp_address;
   logic [7:0]        rsp_data_byte;
   logic [LINE_W-1:0] rsp_line_number;
   logic [7:0]        rsp_record_type;
   logic [7:0]        rsp_due_checksum;

   char_word_t    file_chars[$];
   parse_result_t parsed_results[$];
   logic [7:0]    line_bytes[$];
   int            words_left = 0;
   int            failures = 0;
   bit            burst_mode = 1'b0;
   bit            drain_next = 1'b0;

   // Parser state as predicted by the testbench.
   phase_type         pos = PH_COLON;
   logic [3:0]        hi_nib = '0;
   logic              hi_bad = 1'b0;
   logic [7:0]        count = '0;
   logic [15:0]       rec_addr = '0;
   logic [7:0]        rec_type = '0;
   logic [7:0]        idx = '0;
   logic [7:0]        sum = '0;
   logic [15:0]       pair = '0;
   logic [15:0]       upper = '0;
   logic [LINE_W-1:0] line_no = 1;

   intel_hex_record_parser_unit #(
      .LINE_NUMBER_WIDTH(LINE_W)
   ) dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_end_of_stream    (req_end_of_stream),
      .req_character        (req_character),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_kind             (rsp_kind),
      .rsp_error_code       (rsp_error_code),
      .rsp_address          (rsp_address),
      .rsp_data_byte        (rsp_data_byte),
      .rsp_line_number      (rsp_line_number),
      .rsp_record_type      (rsp_record_type),
      .rsp_due_checksum     (rsp_due_checksum)
   );

   always #4 clock = ~clock;

   // Hex value of one character, with bit 4 set when it is not a hex digit.
   function automatic logic [4:0] nibble_of(input logic [7:0] ch);
      if (ch >= CH_ZERO && ch <= CH_NINE) return {1'b0, 4'(ch - CH_ZERO)};
      if (ch >= CH_UPPER_A && ch <= CH_UPPER_F) return {1'b0, 4'(ch - CH_UPPER_A + 8'd10)};
      if (ch >= CH_LOWER_A && ch <= CH_LOWER_F) return {1'b0, 4'(ch - CH_LOWER_A + 8'd10)};
      return 5'h10;
   endfunction

   // Queues one expected result, tagged with the current line and type.
   task automatic note_result(input kind_type k, input err_type e, input logic [31:0] a,
                              input logic [7:0] d, input logic [7:0] x);
      parse_result_t r;
      r.kind    = k;
      r.code    = e;
      r.address = a;
      r.data    = d;
      r.line    = line_no;
      r.rtype   = rec_type;
      r.csum    = x;
      parsed_results.insert(parsed_results.size(), r);
   endtask

   task automatic halt_with(input err_type e, input logic [7:0] x);
      pos = PH_HALT;
      note_result(KIND_ERROR, e, 32'h0, 8'h00, x);
   endtask

   // A line ended after a good checksum: act on the record type.
   task automatic close_line();
      logic [31:0] base;
      base = {upper, rec_addr};
      if (rec_type == REC_EOF) begin
         pos = PH_HALT;
         note_result(KIND_EOF, NO_ERROR, base, 8'h00, 8'h00);
      end else if (rec_type == REC_SEG || rec_type == REC_START) begin
         halt_with(ERR_UNIMPL, 8'h00);
      end else if (rec_type == REC_UPPER && count != 8'd2) begin
         halt_with(ERR_COUNT, 8'h00);
      end else if (rec_type == REC_DATA || rec_type == REC_SSA || rec_type == REC_UPPER) begin
         if (rec_type == REC_UPPER) begin
            upper = pair;
         end
         pos = PH_COLON;
         note_result(KIND_RECORD, NO_ERROR, base, 8'h00, 8'h00);
         if (line_no != '1) begin
            line_no = line_no + 1'b1;
         end
      end else begin
         halt_with(ERR_UNKNOWN, 8'h00);
      end
   endtask

   // Advances the predicted parser by one accepted word.
   task automatic parse_char(input logic eos, input logic [7:0] ch);
      logic [4:0] dg;
      logic [7:0] b;
      logic [7:0] want;
      if (pos == PH_HALT) begin
         return;
      end
      if (eos || ch == CH_NEWLINE) begin
         if (pos == PH_COLON) begin
            halt_with(eos ? ERR_EOF : ERR_NO_COLON, 8'h00);
         end else if (pos != PH_TAIL) begin
            halt_with(ERR_SHORT, 8'h00);
         end else begin
            close_line();
         end
      end else if (pos == PH_COLON) begin
         if (ch != CH_COLON) begin
            halt_with(ERR_NO_COLON, 8'h00);
         end else begin
            hi_nib   = '0;
            hi_bad   = 1'b0;
            count    = '0;
            rec_addr = '0;
            rec_type = '0;
            idx      = '0;
            sum      = '0;
            pair     = '0;
            pos      = PH_CNT_HI;
         end
      end else if (pos == PH_TAIL) begin
         halt_with(ERR_EXTRA, 8'h00);
      end else begin
         dg = nibble_of(ch);
         if (pos[0]) begin
            // First digit of a pair: only remembered.
            hi_nib = dg[3:0];
            hi_bad = dg[4];
            pos = phase_type'(pos + 1'b1);
         end else if (hi_bad || dg[4]) begin
            halt_with(ERR_DIGIT, 8'h00);
         end else begin
            b = {hi_nib, dg[3:0]};
            case (pos)
               PH_CNT_LO: begin
                  count = b;
                  sum = sum + b;
                  pos = PH_ADH_HI;
               end
               PH_ADH_LO: begin
                  rec_addr = {b, 8'h00};
                  sum = sum + b;
                  pos = PH_ADL_HI;
               end
               PH_ADL_LO: begin
                  rec_addr[7:0] = b;
                  sum = sum + b;
                  pos = PH_TYP_HI;
               end
               PH_TYP_LO: begin
                  rec_type = b;
                  sum = sum + b;
                  pos = (count != 8'd0) ? PH_DAT_HI : PH_SUM_HI;
               end
               PH_DAT_LO: begin
                  if (idx == 8'd0) begin
                     pair = {b, 8'h00};
                  end else if (idx == 8'd1) begin
                     pair[7:0] = b;
                  end
                  sum = sum + b;
                  if (rec_type == REC_DATA) begin
                     note_result(KIND_DATA, NO_ERROR, {upper, rec_addr} + {24'h0, idx}, b, 8'h00);
                  end
                  idx = idx + 1'b1;
                  pos = (idx < count) ? PH_DAT_HI : PH_SUM_HI;
               end
               default: begin
                  want = 8'h00 - sum;
                  if (b != want) begin
                     halt_with(ERR_CHECKSUM, want);
                  end else begin
                     pos = PH_TAIL;
                  end
               end
            endcase
         end
      end
   endtask

   // Gap length: mostly none or short, now and then long.
   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [15:0] pick_addr();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return 16'hFFFF;
      if (r == 1) return 16'h0000;
      return 16'($urandom);
   endfunction

   // Data lengths are mostly small, sometimes medium, with a rare near-maximal record.
   function automatic int pick_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 88) return $urandom_range(0, 16);
      if (r < 99) return $urandom_range(17, 64);
      return $urandom_range(200, 255);
   endfunction

   function automatic logic [7:0] bad_char();
      logic [7:0] c;
      logic [4:0] nib;
      do begin
         c = 8'($urandom_range(0, 255));
         nib = nibble_of(c);
      end while (!nib[4] || c == CH_NEWLINE);
      return c;
   endfunction

   // Any character that neither ends a line nor, optionally, opens one.
   function automatic logic [7:0] stray_char(input bit colon_ok);
      logic [7:0] c;
      do begin
         c = 8'($urandom_range(0, 255));
      end while (c == CH_NEWLINE || (!colon_ok && c == CH_COLON));
      return c;
   endfunction

   // i-th hex digit of the line bytes, in a random letter case.
   function automatic logic [7:0] digit_char(input int i);
      logic [3:0] n;
      n = (i % 2 == 0) ? line_bytes[i / 2][7:4] : line_bytes[i / 2][3:0];
      if (n < 4'd10) return 8'(CH_ZERO + n);
      if ($urandom_range(0, 1) == 1) return 8'(CH_UPPER_A + n - 4'd10);
      return 8'(CH_LOWER_A + n - 4'd10);
   endfunction

   task automatic send(input logic eos, input logic [7:0] ch);
      char_word_t w;
      w.eos   = eos;
      w.ch    = ch;
      w.gap   = burst_mode ? 0 : idle_len();
      w.drain = drain_next;
      drain_next = 1'b0;
      file_chars.insert(file_chars.size(), w);
      words_left++;
   endtask

   // Builds count, address, type, data and a matching checksum.
   task automatic make_line(input logic [7:0] rtype, input logic [15:0] addr, input int len,
                            input int fill);
      logic [7:0] total;
      line_bytes.delete();
      line_bytes.insert(line_bytes.size(), 8'(len));
      line_bytes.insert(line_bytes.size(), addr[15:8]);
      line_bytes.insert(line_bytes.size(), addr[7:0]);
      line_bytes.insert(line_bytes.size(), rtype);
      for (int i = 0; i < len; i++) begin
         line_bytes.insert(line_bytes.size(),
                           (fill < 0) ? 8'($urandom_range(0, 255)) : 8'(fill));
      end
      total = 8'h00;
      foreach (line_bytes[i]) begin
         total = total + line_bytes[i];
      end
      line_bytes.insert(line_bytes.size(), 8'h00 - total);
   endtask

   task automatic send_digits(input int n);
      for (int i = 0; i < n; i++) begin
         send(1'b0, digit_char(i));
      end
   endtask

   task automatic send_terminator(input bit use_eos);
      send(use_eos, use_eos ? 8'($urandom_range(0, 255)) : CH_NEWLINE);
   endtask

   task automatic send_line(input logic [7:0] rtype, input logic [15:0] addr, input int len,
                            input int fill, input bit use_eos);
      make_line(rtype, addr, len, fill);
      send(1'b0, CH_COLON);
      send_digits(2 * line_bytes.size());
      send_terminator(use_eos);
   endtask

   // Ends the stream with one randomly chosen error or an end-of-file record.
   task automatic send_ending();
      ending_t how;
      int p;
      how = ending_t'($urandom_range(0, 10));
      case (how)
         END_NO_COLON: send(1'b0, stray_char(1'b0));
         END_EMPTY_LINE: send(1'b0, CH_NEWLINE);
         END_EOS: send(1'b1, 8'($urandom_range(0, 255)));
         END_DIGIT: begin
            make_line(REC_DATA, pick_addr(), $urandom_range(0, 8), -1);
            send(1'b0, CH_COLON);
            p = 2 * $urandom_range(0, line_bytes.size() - 1);
            send_digits(p);
            if ($urandom_range(0, 1) == 1) begin
               send(1'b0, bad_char());
               send(1'b0, digit_char(p + 1));
            end else begin
               send(1'b0, digit_char(p));
               send(1'b0, bad_char());
            end
         end
         END_SHORT: begin
            make_line(($urandom_range(0, 1) == 1) ? REC_DATA : REC_UPPER, pick_addr(),
                      $urandom_range(0, 8), -1);
            send(1'b0, CH_COLON);
            p = $urandom_range(0, 2 * line_bytes.size() - 1);
            // A bad first digit of a cut-off pair still reads as a short line.
            if (p % 2 == 1 && $urandom_range(0, 1) == 1) begin
               send_digits(p - 1);
               send(1'b0, bad_char());
            end else begin
               send_digits(p);
            end
            send_terminator($urandom_range(0, 1) == 1);
         end
         END_CHECKSUM: begin
            make_line(REC_DATA, pick_addr(), $urandom_range(0, 8), -1);
            line_bytes[line_bytes.size() - 1] += 8'($urandom_range(1, 255));
            send(1'b0, CH_COLON);
            send_digits(2 * line_bytes.size());
            send_terminator(1'b0);
         end
         END_EXTRA: begin
            make_line(REC_DATA, pick_addr(), $urandom_range(0, 8), -1);
            send(1'b0, CH_COLON);
            send_digits(2 * line_bytes.size());
            send(1'b0, ($urandom_range(0, 1) == 1) ? 8'h0D : stray_char(1'b1));
         end
         END_UNKNOWN: send_line(8'($urandom_range(6, 255)), pick_addr(),
                                $urandom_range(0, 8), -1, $urandom_range(0, 1) == 1);
         END_UNIMPL: send_line(($urandom_range(0, 1) == 1) ? REC_SEG : REC_START, pick_addr(),
                               $urandom_range(0, 4), -1, 1'b0);
         END_COUNT: begin
            p = $urandom_range(0, 7);
            send_line(REC_UPPER, pick_addr(), (p >= 2) ? p + 1 : p, -1, 1'b0);
         end
         default: send_line(REC_EOF, pick_addr(),
                            ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0, -1,
                            $urandom_range(0, 1) == 1);
      endcase
   endtask

   task automatic compare_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
         failures++;
      end
   endtask

   task automatic check_result();
      parse_result_t r;
      if (parsed_results.size() == 0) begin
         $display("%0t: result word expected none actual kind %0d code %0d", $time,
                  rsp_kind, rsp_error_code);
         failures++;
      end else begin
         r = parsed_results.pop_front();
         compare_field("kind", r.kind, rsp_kind);
         compare_field("error_code", r.code, rsp_error_code);
         compare_field("address", r.address, rsp_address);
         compare_field("data_byte", r.data, rsp_data_byte);
         compare_field("line_number", r.line, rsp_line_number);
         compare_field("record_type", r.rtype, rsp_record_type);
         compare_field("due_checksum", r.csum, rsp_due_checksum);
      end
   endtask

   // Driver: feeds the queued character words, predicting each one accepted.
   int idle_left = 0;
   char_word_t next_word;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         idle_left = 0;
      end else begin
         if (req_valid && !req_stall) begin
            parse_char(req_end_of_stream, req_character);
            words_left--;
            if (file_chars.size() > 0) begin
               idle_left = file_chars[0].gap;
            end
         end
         if (!(req_valid && req_stall)) begin
            if (idle_left > 0) begin
               idle_left--;
               req_valid <= 1'b0;
            end else if (file_chars.size() > 0 &&
                         (!file_chars[0].drain || parsed_results.size() == 0)) begin
               next_word = file_chars.pop_front();
               req_valid <= 1'b1;
               req_end_of_stream <= next_word.eos;
               req_character <= next_word.ch;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: checks accepted result words and stalls at random, with one long hold.
   int hold_left = 0;
   int stall_left = 0;
   int quiet_left = 0;
   int results_seen = 0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            check_result();
            results_seen++;
            if (results_seen == HOLD_AFTER) begin
               hold_left = HOLD_CYCLES;
            end
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else if (quiet_left > 0) begin
            quiet_left--;
            rsp_stall <= 1'b0;
         end else begin
            stall_left = idle_len();
            rsp_stall <= 1'b0;
            if ($urandom_range(0, 39) == 0) begin
               quiet_left = $urandom_range(30, 150);
            end
         end
      end
   end

   // Watchdog.
   int cycles = 0;

   always @(posedge clock) begin
      cycles++;
      if (cycles == CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   initial begin
      int n;
      int r;
      // Upper word FFFF from lower-level digits, closed by end of stream, then
      // a two-byte data record at FFFF so the byte address wraps to zero.
      send_line(REC_UPPER, 16'h0000, 2, 255, 1'b1);
      send_line(REC_DATA, 16'hFFFF, 2, -1, 1'b0);

      // Well-formed records with random content.
      n = 0;
      while (words_left < ITEM_TARGET) begin
         if ($urandom_range(0, 5) == 0) begin
            burst_mode = ($urandom_range(0, 2) == 0);
         end
         if (n == 30 || $urandom_range(0, 32) == 0) begin
            drain_next = 1'b1;
         end
         r = $urandom_range(0, 99);
         if (r < 70) begin
            send_line(REC_DATA, pick_addr(), pick_len(), -1, $urandom_range(0, 6) == 0);
         end else if (r < 85) begin
            send_line(REC_SSA, pick_addr(), $urandom_range(0, 8), -1,
                      $urandom_range(0, 6) == 0);
         end else begin
            send_line(REC_UPPER, pick_addr(), 2, ($urandom_range(0, 7) == 0) ? 255 : -1,
                      $urandom_range(0, 6) == 0);
         end
         n++;
      end

      // The halting line, then noise that the halted parser must ignore.
      burst_mode = 1'b0;
      send_ending();
      send(1'b0, 8'h00);
      send(1'b0, 8'hFF);
      for (int i = 0; i < 40; i++) begin
         send($urandom_range(0, 7) == 0, 8'($urandom_range(0, 255)));
      end

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      while (words_left > 0 || parsed_results.size() > 0) begin
         @(negedge clock);
      end
      repeat (20) @(posedge clock);
      if (failures == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
